// ----- rtl/core/wildcard_string_match_assert.svh -----
// assertion macros for the wildcard string matcher
`ifndef WILDCARD_STRING_MATCH_ASSERT_SVH
`define WILDCARD_STRING_MATCH_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define WSM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wildcard_string_match: same-cycle check failed");

// next-cycle implication under synchronous active-low reset
`define WSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wildcard_string_match: next-cycle check failed");

`endif

// ----- rtl/core/wsm_pkg.sv -----
// shared types, codes and helpers for the wildcard string matcher
`default_nettype none

package wsm_pkg;

    localparam logic [7:0] CH_ANY_ONE   = 8'h3F;
    localparam logic [7:0] CH_ANY_RUN   = 8'h2A;
    localparam logic [7:0] CH_END       = 8'h00;
    localparam logic       MODE_PATTERN = 1'b0;
    localparam logic       MODE_SUBJECT = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_wsm_in;

    typedef struct packed {
        logic match;
        logic overflow;
    } t_wsm_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL
    } t_wsm_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_wsm_cmd;

    typedef struct packed {
        logic term;
        logic finish;
    } t_wsm_status;

    // count of continuation bytes announced by a utf-8 lead byte
    function automatic logic [2:0] lead_ones(input logic [7:0] b);
        logic [2:0] cnt;
        logic       run;
        cnt = 3'd0;
        run = 1'b1;
        for (int i = 6; i >= 0; i--) begin
            run = run & b[i];
            cnt = cnt + {2'b00, run};
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wsm_ctrl.sv -----
// control state machine: request acceptance and match walk sequencing
`default_nettype none

module wsm_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wsm_pkg::t_wsm_status i_status,
    output wsm_pkg::t_wsm_cmd    o_cmd,
    output logic                 o_busy,
    output logic                 o_done
);

    wsm_pkg::t_wsm_state r_state;
    wsm_pkg::t_wsm_state n_state;
    logic                r_done;
    logic                n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsm_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_busy     = 1'b1;
        case (r_state)
            wsm_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
                if (i_start && i_status.term) begin
                    n_state = wsm_pkg::ST_FETCH;
                end
            end
            wsm_pkg::ST_FETCH: begin
                n_state = wsm_pkg::ST_EVAL;
            end
            wsm_pkg::ST_EVAL: begin
                o_cmd.step = 1'b1;
                if (i_status.finish) begin
                    n_state = wsm_pkg::ST_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = wsm_pkg::ST_FETCH;
                end
            end
            default: begin
                n_state = wsm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- rtl/core/wsm_dp.sv -----
// datapath: pattern and subject stores, lengths, flags and backtracking walk
`default_nettype none

module wsm_dp #(
    parameter int PATTERN_BYTES = 64,
    parameter int SUBJECT_BYTES = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wsm_pkg::t_wsm_in      i_req,
    input  wsm_pkg::t_wsm_cmd     i_cmd,
    output wsm_pkg::t_wsm_status  o_status,
    output wsm_pkg::t_wsm_out     o_res
);

    localparam int PA = $clog2(PATTERN_BYTES);
    localparam int SA = $clog2(SUBJECT_BYTES);
    localparam int PW = $clog2(PATTERN_BYTES + 1);
    localparam int SW = $clog2(SUBJECT_BYTES + 1);

    logic [7:0] pat_mem [PATTERN_BYTES];
    logic [7:0] subj_mem [SUBJECT_BYTES];
    logic [7:0] r_pat_rd;
    logic [7:0] r_subj_rd;

    logic [PW-1:0] r_plen;
    logic          r_povf;
    logic          r_open;
    logic [SW-1:0] r_slen;
    logic          r_sovf;
    logic [SW-1:0] r_s, n_s, r_sbase, n_sbase;
    logic [PW-1:0] r_p, n_p, r_pbase, n_pbase;
    logic          r_star, n_star;
    wsm_pkg::t_wsm_out r_res;

    logic          is_zero;
    logic          pat_load;
    logic          subj_load;
    logic [PW-1:0] pbase_ld;
    logic          pat_fits;
    logic          subj_fits;
    logic          pat_we;
    logic          subj_we;
    logic [7:0]    pc;
    logic [SW+3:0] s_skip;
    logic [PW:0]   p_inc;
    logic          finish;
    logic          result;

    assign is_zero   = (i_req.data_byte == wsm_pkg::CH_END);
    assign pat_load  = i_cmd.load && (i_req.mode == wsm_pkg::MODE_PATTERN);
    assign subj_load = i_cmd.load && (i_req.mode == wsm_pkg::MODE_SUBJECT);
    assign pbase_ld  = r_open ? r_plen : '0;
    assign pat_fits  = (pbase_ld < PW'(PATTERN_BYTES));
    assign subj_fits = (r_slen < SW'(SUBJECT_BYTES));
    assign pat_we    = pat_load && !is_zero && pat_fits;
    assign subj_we   = subj_load && !is_zero && subj_fits;

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            pat_mem[pbase_ld[PA-1:0]] <= i_req.data_byte;
        end
        r_pat_rd <= pat_mem[r_p[PA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (subj_we) begin
            subj_mem[r_slen[SA-1:0]] <= i_req.data_byte;
        end
        r_subj_rd <= subj_mem[r_s[SA-1:0]];
    end

    // one walk step on the fetched pattern and subject bytes
    always_comb begin
        n_s     = r_s;
        n_p     = r_p;
        n_sbase = r_sbase;
        n_pbase = r_pbase;
        n_star  = r_star;
        finish  = 1'b0;
        result  = 1'b0;
        s_skip  = '0;
        p_inc   = '0;
        pc      = (r_p < r_plen) ? r_pat_rd : wsm_pkg::CH_END;
        if (r_s < r_slen) begin
            if (pc == wsm_pkg::CH_ANY_ONE) begin
                n_p = PW'(r_p + 1'b1);
                if (r_subj_rd[7]) begin
                    s_skip = (SW+4)'(r_s) + (SW+4)'(wsm_pkg::lead_ones(r_subj_rd))
                             + (SW+4)'(1);
                    n_s = (s_skip >= (SW+4)'(r_slen)) ? r_slen : s_skip[SW-1:0];
                end else begin
                    n_s = SW'(r_s + 1'b1);
                end
            end else if (pc == wsm_pkg::CH_ANY_RUN) begin
                p_inc   = (PW+1)'(r_p) + (PW+1)'(1);
                n_star  = 1'b1;
                n_sbase = r_s;
                n_pbase = p_inc[PW-1:0];
                n_p     = p_inc[PW-1:0];
                if (p_inc >= (PW+1)'(r_plen)) begin
                    finish = 1'b1;
                    result = 1'b1;
                end
            end else if (r_subj_rd != pc) begin
                if (!r_star) begin
                    finish = 1'b1;
                end else begin
                    n_sbase = SW'(r_sbase + 1'b1);
                    n_s     = SW'(r_sbase + 1'b1);
                    n_p     = r_pbase;
                end
            end else begin
                n_s = SW'(r_s + 1'b1);
                n_p = PW'(r_p + 1'b1);
            end
        end else begin
            finish = 1'b1;
            p_inc  = (PW+1)'(r_p) + (PW+1)'(pc == wsm_pkg::CH_ANY_RUN);
            result = (p_inc >= (PW+1)'(r_plen));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
            r_povf <= 1'b0;
            r_open <= 1'b0;
            r_slen <= '0;
            r_sovf <= 1'b0;
        end else begin
            if (pat_load) begin
                if (is_zero) begin
                    r_open <= 1'b0;
                    r_plen <= pbase_ld;
                    r_povf <= r_open & r_povf;
                end else begin
                    r_open <= 1'b1;
                    r_plen <= pat_fits ? PW'(pbase_ld + 1'b1) : pbase_ld;
                    r_povf <= (r_open & r_povf) | !pat_fits;
                end
            end
            if (subj_load && !is_zero) begin
                if (subj_fits) begin
                    r_slen <= SW'(r_slen + 1'b1);
                end else begin
                    r_sovf <= 1'b1;
                end
            end
            if (i_cmd.step && finish) begin
                r_slen <= '0;
                r_sovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (subj_load && is_zero) begin
            r_s     <= '0;
            r_p     <= '0;
            r_sbase <= '0;
            r_pbase <= '0;
            r_star  <= 1'b0;
        end else if (i_cmd.step) begin
            r_s     <= n_s;
            r_p     <= n_p;
            r_sbase <= n_sbase;
            r_pbase <= n_pbase;
            r_star  <= n_star;
        end
        if (i_cmd.step && finish) begin
            r_res.match    <= result;
            r_res.overflow <= r_povf | r_sovf;
        end
    end

    assign o_status.term   = (i_req.mode == wsm_pkg::MODE_SUBJECT) && is_zero;
    assign o_status.finish = finish;
    assign o_res           = r_res;

endmodule

`default_nettype wire

// ----- rtl/core/wildcard_string_match.sv -----
// top level of the wildcard string matcher
//
//  channel   ports                        handshake
//  request   start, busy, i_req           taken when start high and busy low
//  result    o_done, o_res                one-cycle strobe, always taken
//
// a pattern or subject byte takes one cycle, busy stays low while loading
// the closing zero of a subject starts the walk: each walk step reads the
// pattern/subject stores in FETCH, then evaluates in EVAL; the done strobe is registered
// walk length depends on data, worst case about pattern length times subject length steps
// reset clears lengths, flags and control; stores need no clearing pass
// results cannot be stalled
`default_nettype none

module wildcard_string_match #(
    parameter int PATTERN_BYTES = 64,
    parameter int SUBJECT_BYTES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wsm_pkg::t_wsm_in    i_req,
    output logic                busy,
    output logic                o_done,
    output wsm_pkg::t_wsm_out   o_res
);

    wsm_pkg::t_wsm_cmd    cmd;
    wsm_pkg::t_wsm_status status;

    wsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    wsm_dp #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .SUBJECT_BYTES (SUBJECT_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_status (status),
        .o_res    (o_res)
    );

`include "wildcard_string_match_assert.svh"

    `WSM_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `WSM_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy && $past(busy))
    `WSM_ASSERT_NEXT(a_term_busy, i_clk, i_rst_n, start && !busy && status.term, busy)

endmodule

`default_nettype wire
